### sv/top_k_candidate_selector_top_macros.svh
// Assertion macros used by the top-k candidate selector RTL.
`ifndef TOP_K_CANDIDATE_SELECTOR_TOP_MACROS_SVH
`define TOP_K_CANDIDATE_SELECTOR_TOP_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define TKCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define TKCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/tkcs_pkg.sv
// Types, constants and the ordering function of the top-k candidate selector.
package tkcs_pkg;

   localparam int SEED_W       = 64;
   localparam int SCORE_W      = 32;
   localparam int POS_W        = 4;
   localparam int KEEP_LIMIT_W = 5;
   localparam int REQ_DATA_W   = 192;
   localparam int RSP_DATA_W   = 200;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [KEEP_LIMIT_W-1:0] KEEP_LIMIT_RESET = 5'd16;

   // Register index decoded from paddr[2]
   localparam logic REG_KEEP_LIMIT = 1'b0;

   // Item kinds carried on req_tuser
   localparam logic ACTION_OFFER = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   typedef struct packed {
      logic [SEED_W-1:0]  seed;
      logic [SCORE_W-1:0] total;
      logic [SCORE_W-1:0] frequency;
      logic [SCORE_W-1:0] gap;
      logic [SCORE_W-1:0] rank;
   } entry_type;

   // Control that the sequencer drives into every cell of the chain
   typedef struct packed {
      logic insert;   // place the offered candidate, shift worse entries right
      logic grow;     // the chain may gain one valid entry
      logic shift;    // move every entry one cell toward the head
   } chain_ctrl_type;

   // True when cand orders strictly ahead of held: total, then frequency, then seed
   function automatic logic better(input entry_type cand, input entry_type held);
      logic lt_total;
      logic eq_total;
      logic lt_freq;
      logic eq_freq;
      logic lt_seed;
      lt_total = cand.total < held.total;
      eq_total = cand.total == held.total;
      lt_freq  = cand.frequency < held.frequency;
      eq_freq  = cand.frequency == held.frequency;
      lt_seed  = cand.seed < held.seed;
      return lt_total || (eq_total && (lt_freq || (eq_freq && lt_seed)));
   endfunction

endpackage

### sv/tkcs_cell.sv
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
module tkcs_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  tkcs_pkg::chain_ctrl_type ctrl,
   input  tkcs_pkg::entry_type     cand,
   input  logic                    left_take,
   input  logic                    left_valid,
   input  tkcs_pkg::entry_type     left_entry,
   input  logic                    right_valid,
   input  tkcs_pkg::entry_type     right_entry,
   output logic                    take,
   output logic                    valid,
   output tkcs_pkg::entry_type     entry
);
   import tkcs_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   entry_type entry_ff;
   entry_type entry_in;

   // Candidate lands here or further left: empty cell or beaten entry
   assign take = !valid_ff || better(cand, entry_ff);

   // Insert, shift toward the head, or hold
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctrl.insert && take) begin
         if (left_take) begin
            entry_in = left_entry;
            valid_in = left_valid && (valid_ff || ctrl.grow);
         end else begin
            entry_in = cand;
            valid_in = 1'b1;
         end
      end else if (ctrl.shift) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign valid = valid_ff;
   assign entry = entry_ff;

endmodule

### sv/tkcs_chain.sv
// Row of sorted cells, best entry in cell zero.
module tkcs_chain #(
   parameter int MAX_KEEP = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tkcs_pkg::chain_ctrl_type ctrl,
   input  tkcs_pkg::entry_type     cand,
   output tkcs_pkg::entry_type     head,
   output logic [MAX_KEEP-1:0]     valid,
   output logic                    any_beaten
);
   import tkcs_pkg::*;

   logic [MAX_KEEP-1:0] take;
   entry_type           cell_entry [MAX_KEEP];

   for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
      logic      left_take;
      logic      left_valid;
      entry_type left_entry;
      logic      right_valid;
      entry_type right_entry;

      // Head cell has no left neighbor
      if (i == 0) begin : g_head
         assign left_take  = 1'b0;
         assign left_valid = 1'b0;
         assign left_entry = cand;
      end else begin : g_body
         assign left_take  = take[i-1];
         assign left_valid = valid[i-1];
         assign left_entry = cell_entry[i-1];
      end

      // Tail cell refills with an empty slot on a shift
      if (i == MAX_KEEP - 1) begin : g_tail
         assign right_valid = 1'b0;
         assign right_entry = cell_entry[i];
      end else begin : g_next
         assign right_valid = valid[i+1];
         assign right_entry = cell_entry[i+1];
      end

      tkcs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .cand        (cand),
         .left_take   (left_take),
         .left_valid  (left_valid),
         .left_entry  (left_entry),
         .right_valid (right_valid),
         .right_entry (right_entry),
         .take        (take[i]),
         .valid       (valid[i]),
         .entry       (cell_entry[i])
      );
   end

   assign head       = cell_entry[0];
   assign any_beaten = |(take & valid);

endmodule

### sv/top_k_candidate_selector_top.sv
// Top level of the top-k candidate selector: stream ports, register port, flush sequencer.
// Keeps the best keep_limit candidates (lower total, then lower frequency, then lower
// seed) in a row of MAX_KEEP cells that compare the offered candidate in parallel and
// shift worse entries one cell down. Offers are accepted on consecutive cycles while no
// flush is in progress. A flush item holds req_tready low while the held entries shift
// out of cell zero, one result item per cycle the output register is free, giving
// max(1, held count) result items in all. An empty flush gives one result item with
// tuser set and tlast set. The result register lets the next offer enter while the last
// result still waits on rsp_tready.
`include "top_k_candidate_selector_top_macros.svh"

module top_k_candidate_selector_top #(
   parameter int MAX_KEEP = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: cand_seed[63:0], cand_total[95:64], cand_frequency[127:96],
   //            cand_gap[159:128], cand_rank[191:160]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tkcs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: action (0 offer, 1 flush)
   input  logic                                req_tuser,
   // rsp_tdata: out_seed[63:0], out_total[95:64], out_frequency[127:96],
   //            out_gap[159:128], out_rank[191:160], position[195:192], zero fill
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tkcs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   // rsp_tuser: list_empty
   output logic                                rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tkcs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tkcs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tkcs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import tkcs_pkg::*;

   localparam int CNT_W = $clog2(MAX_KEEP + 1);
   localparam int CMP_W = (CNT_W > KEEP_LIMIT_W) ? CNT_W : KEEP_LIMIT_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type                 state_ff;
   state_type                 state_in;
   logic [CNT_W-1:0]          held_count_ff;
   logic [CNT_W-1:0]          held_count_in;
   logic [POS_W-1:0]          pos_ff;
   logic [POS_W-1:0]          pos_in;
   logic [KEEP_LIMIT_W-1:0]   keep_limit_ff;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;
   logic [RSP_DATA_W-1:0]     rsp_data_in;
   logic                      rsp_last_ff;
   logic                      rsp_last_in;
   logic                      rsp_empty_ff;
   logic                      rsp_empty_in;

   entry_type                 cand;
   entry_type                 head;
   logic [MAX_KEEP-1:0]       chain_valid;
   logic                      any_beaten;
   chain_ctrl_type            ctrl;

   logic                      req_accept;
   logic                      offer;
   logic                      full;
   logic                      slot_free;
   logic                      rsp_load;
   logic                      csr_write;

   // Unpack the offered candidate
   assign cand.seed      = req_tdata[63:0];
   assign cand.total     = req_tdata[95:64];
   assign cand.frequency = req_tdata[127:96];
   assign cand.gap       = req_tdata[159:128];
   assign cand.rank      = req_tdata[191:160];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign offer      = req_accept && (req_tuser == ACTION_OFFER);

   // Full at the limit (zero acts as one) or at the built depth
   always_comb begin
      if (held_count_ff == CNT_W'(MAX_KEEP)) begin
         full = 1'b1;
      end else if (keep_limit_ff == '0) begin
         full = (held_count_ff != '0);
      end else begin
         full = (CMP_W'(held_count_ff) >= CMP_W'(keep_limit_ff));
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign rsp_load  = (state_ff == ST_EMIT) && slot_free;

   // Drive the chain: insert on an accepted offer that finds room or beats an entry, shift on each emitted entry
   always_comb begin
      ctrl.insert = offer && (!full || any_beaten);
      ctrl.grow   = !full;
      ctrl.shift  = rsp_load && (held_count_ff != '0);
   end

   tkcs_chain #(
      .MAX_KEEP (MAX_KEEP)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .cand       (cand),
      .head       (head),
      .valid      (chain_valid),
      .any_beaten (any_beaten)
   );

   // Sequence the flush and track the held count
   always_comb begin
      state_in      = state_ff;
      held_count_in = held_count_ff;
      pos_in        = pos_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctrl.insert && ctrl.grow) begin
               held_count_in = held_count_ff + 1'b1;
            end
            if (req_accept && (req_tuser == ACTION_FLUSH)) begin
               state_in = ST_EMIT;
               pos_in   = '0;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               if (held_count_ff == '0) begin
                  rsp_data_in  = '0;
                  rsp_last_in  = 1'b1;
                  rsp_empty_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  rsp_data_in  = {{(RSP_DATA_W - REQ_DATA_W - POS_W){1'b0}}, pos_ff,
                                  head.rank, head.gap, head.frequency, head.total,
                                  head.seed};
                  rsp_last_in  = (held_count_ff == CNT_W'(1));
                  rsp_empty_in = 1'b0;
                  held_count_in = held_count_ff - 1'b1;
                  pos_in        = pos_ff + 1'b1;
                  if (held_count_ff == CNT_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold a result until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_count_ff <= '0;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_count_ff <= held_count_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_empty_ff;

   // Register port: word index in paddr[2], low address bits ignored
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_limit_ff <= KEEP_LIMIT_RESET;
      end else if (csr_write && (csr_paddr[2] == REG_KEEP_LIMIT)) begin
         keep_limit_ff <= csr_pwdata[KEEP_LIMIT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_KEEP_LIMIT) ?
                       CSR_DATA_W'(keep_limit_ff) : '0;

   // Valid cells and the held count must agree
   `TKCS_ASSERT_NOW(a_count_matches_cells, clock, reset, 1'b1, $countones(chain_valid) == held_count_ff, "held count disagrees with valid cells")
   // Valid cells always form a run starting at the head
   `TKCS_ASSERT_NOW(a_cells_packed, clock, reset, 1'b1, (chain_valid & (chain_valid + 1'b1)) == '0, "gap in valid cells")
   // The last result of a flush leaves the chain empty
   `TKCS_ASSERT_NEXT(a_flush_empties, clock, reset, rsp_load && rsp_last_in, held_count_ff == '0, "chain not empty after flush")

endmodule
